@@ rtl/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, codes and fixed-point constants of the docking pose controller.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int AW = 28;
    localparam int WW = 30;
    localparam int XW = 36;
    localparam int IW = 5;

    localparam logic signed [WW-1:0] PI_W      = WW'(52707179);
    localparam logic signed [WW-1:0] TWO_PI_W  = WW'(105414358);
    localparam logic signed [AW-1:0] PI_Q      = AW'(52707179);
    localparam logic signed [AW-1:0] HALF_PI_Q = AW'(26353589);
    localparam logic [AW-1:0]        ROT_TOL_Q = AW'(838861);
    localparam logic [17:0]          ROT_CAP   = 18'd1229;
    localparam logic [23:0]          INV_GAIN  = 24'd10188014;

    localparam logic [1:0] FUNC_APPROACH = 2'd0;
    localparam logic [1:0] FUNC_BACK_OFF = 2'd1;
    localparam logic [1:0] FUNC_ROTATE   = 2'd2;

    localparam logic [1:0] STAT_MOVING  = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    localparam logic [2:0] CFG_GOAL_X        = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y        = 3'd1;
    localparam logic [2:0] CFG_GOAL_HEADING  = 3'd2;
    localparam logic [2:0] CFG_GAIN_DISTANCE = 3'd3;
    localparam logic [2:0] CFG_GAIN_BEARING  = 3'd4;
    localparam logic [2:0] CFG_GAIN_FINAL    = 3'd5;
    localparam logic [2:0] CFG_SPEED_CAP     = 3'd6;
    localparam logic [2:0] CFG_TURN_CAP      = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ITER,
        ST_RHO_LO,
        ST_RHO_HI,
        ST_ALPHA,
        ST_BETA,
        ST_PROD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic iter;
        logic rho_lo;
        logic rho_hi;
        logic alpha;
        logic beta;
        logic prod;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic iter_last;
    } t_dp_status;

    function automatic logic signed [AW-1:0] atan_q(input logic [IW-1:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0:    r = AW'(13176795);
            5'd1:    r = AW'(7778716);
            5'd2:    r = AW'(4110060);
            5'd3:    r = AW'(2086331);
            5'd4:    r = AW'(1047214);
            5'd5:    r = AW'(524117);
            5'd6:    r = AW'(262123);
            5'd7:    r = AW'(131069);
            5'd8:    r = AW'(65536);
            5'd9:    r = AW'(32768);
            5'd10:   r = AW'(16384);
            5'd11:   r = AW'(8192);
            5'd12:   r = AW'(4096);
            5'd13:   r = AW'(2048);
            5'd14:   r = AW'(1024);
            5'd15:   r = AW'(512);
            5'd16:   r = AW'(256);
            5'd17:   r = AW'(128);
            5'd18:   r = AW'(64);
            5'd19:   r = AW'(32);
            5'd20:   r = AW'(16);
            5'd21:   r = AW'(8);
            5'd22:   r = AW'(4);
            5'd23:   r = AW'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [AW-1:0] wrap_angle(input logic signed [WW-1:0] a);
        logic signed [WW-1:0] r;
        r = a;
        if (r >= PI_W) begin
            r = r - TWO_PI_W;
        end else if (r < -PI_W) begin
            r = r + TWO_PI_W;
        end
        if (r >= PI_W) begin
            r = r - TWO_PI_W;
        end else if (r < -PI_W) begin
            r = r + TWO_PI_W;
        end
        return r[AW-1:0];
    endfunction

endpackage

@@ rtl/dpc_pose_if.sv @@
// ----------------------------------------------------------------------------
// dpc_pose_if
// Pose sample channel: one odometry word per handshake.
// ----------------------------------------------------------------------------
interface dpc_pose_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic               phase_start;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;

    modport source (output valid, func, phase_start, robot_x, robot_y, robot_heading,
                    input ready);
    modport sink   (input valid, func, phase_start, robot_x, robot_y, robot_heading,
                    output ready);
endinterface

@@ rtl/dpc_cmd_if.sv @@
// ----------------------------------------------------------------------------
// dpc_cmd_if
// Speed command channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface dpc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic [1:0]         status;

    modport source (output valid, linear_speed, angular_speed, status, input ready);
    modport sink   (input valid, linear_speed, angular_speed, status, output ready);
endinterface

@@ rtl/dpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpc_ctrl
// Sequencer: steps the datapath through capture, CORDIC, products and result.
// ----------------------------------------------------------------------------
module dpc_ctrl import dpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_ITER;
            end
            ST_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_status.iter_last) begin
                    n_state = ST_RHO_LO;
                end
            end
            ST_RHO_LO: begin
                o_cmd.rho_lo = 1'b1;
                n_state      = ST_RHO_HI;
            end
            ST_RHO_HI: begin
                o_cmd.rho_hi = 1'b1;
                n_state      = ST_ALPHA;
            end
            ST_ALPHA: begin
                o_cmd.alpha = 1'b1;
                n_state     = ST_BETA;
            end
            ST_BETA: begin
                o_cmd.beta = 1'b1;
                n_state    = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while waiting");
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result valid without finish step");
    a_iter_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ITER && !i_status.iter_last) |=> r_state == ST_ITER)
        else $error("CORDIC left early");
`endif

endmodule

@@ rtl/dpc_datapath.sv @@
// ----------------------------------------------------------------------------
// dpc_datapath
// Registers, CORDIC vectoring unit, gain products and result selection.
// ----------------------------------------------------------------------------
module dpc_datapath import dpc_pkg::*; #(
    parameter int CORDIC_STEPS           = 16,
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic               i_phase_start,
    input  logic signed [31:0] i_robot_x,
    input  logic signed [31:0] i_robot_y,
    input  logic signed [15:0] i_robot_heading,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic signed [15:0] o_linear_speed,
    output logic signed [15:0] o_angular_speed,
    output logic [1:0]         o_result_status
);

    localparam int TOL_DOCK_I = ((1 << POSITION_FRACTION_BITS) + 50) / 100;
    localparam int TOL_BACK_I = ((2 << POSITION_FRACTION_BITS) + 50) / 100;
    localparam logic [XW-1:0] TOL_DOCK = XW'(TOL_DOCK_I);
    localparam logic [XW-1:0] TOL_BACK = XW'(TOL_BACK_I);
    localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

    logic signed [31:0] r_goal_x, r_goal_y;
    logic signed [15:0] r_goal_heading;
    logic [15:0]        r_gain_distance, r_gain_bearing, r_gain_final;
    logic [14:0]        r_speed_cap, r_turn_cap;
    logic               r_docked, r_turn_sign;

    logic [1:0]         r_func;
    logic               r_start;
    logic signed [31:0] r_rx, r_ry;
    logic signed [26:0] r_theta;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic               r_zero;
    logic [IW-1:0]      r_iter;
    logic [41:0]        r_pl, r_ph;
    logic [XW-1:0]      r_rho;
    logic signed [AW-1:0] r_alpha, r_beta, r_diff;
    logic [AW-1:0]      r_dmag;
    logic [51:0]        r_vprod;
    logic signed [44:0] r_pa, r_pb;
    logic [41:0]        r_rprod;
    logic signed [15:0] r_lin, r_ang;
    logic [1:0]         r_stat;

    logic signed [26:0] gth;
    logic signed [XW-1:0] dx, dy, xs, ys;
    logic signed [AW-1:0] bear;
    logic [59:0]        rho_sum;
    logic [51:0]        v_u;
    logic signed [52:0] vs, vc;
    logic signed [45:0] wsum, wsh, wc;
    logic [14:0]        vb;
    logic [17:0]        rr;
    logic [10:0]        rc;
    logic               alpha_wide, sign_now;
    logic signed [15:0] n_lin, n_ang;
    logic [1:0]         n_stat;
    logic               n_docked, n_turn_sign;

    assign gth                = {r_goal_heading, 11'b0};
    assign dx                 = XW'(r_goal_x) - XW'(r_rx);
    assign dy                 = XW'(r_goal_y) - XW'(r_ry);
    assign xs                 = r_x >>> r_iter;
    assign ys                 = r_y >>> r_iter;
    assign bear               = r_zero ? '0 : r_z;
    assign rho_sum            = {r_ph, 18'b0} + 60'(r_pl);
    assign o_status.iter_last = (r_iter == LAST_ITER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x        <= '0;
            r_goal_y        <= '0;
            r_goal_heading  <= '0;
            r_gain_distance <= 16'd3686;
            r_gain_bearing  <= 16'd6144;
            r_gain_final    <= 16'd1229;
            r_speed_cap     <= 15'd410;
            r_turn_cap      <= 15'd2048;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GOAL_X:        r_goal_x        <= i_cfg_data;
                CFG_GOAL_Y:        r_goal_y        <= i_cfg_data;
                CFG_GOAL_HEADING:  r_goal_heading  <= i_cfg_data[15:0];
                CFG_GAIN_DISTANCE: r_gain_distance <= i_cfg_data[15:0];
                CFG_GAIN_BEARING:  r_gain_bearing  <= i_cfg_data[15:0];
                CFG_GAIN_FINAL:    r_gain_final    <= i_cfg_data[15:0];
                CFG_SPEED_CAP:     r_speed_cap     <= i_cfg_data[14:0];
                CFG_TURN_CAP:      r_turn_cap      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_start <= i_phase_start;
            r_rx    <= i_robot_x;
            r_ry    <= i_robot_y;
            r_theta <= {i_robot_heading, 11'b0};
        end
        if (i_cmd.init) begin
            r_iter <= '0;
            r_zero <= (dx == '0) && (dy == '0);
            if (dx < 0) begin
                r_x <= -dx;
                r_y <= -dy;
                r_z <= (dy >= 0) ? PI_Q : -PI_Q;
            end else begin
                r_x <= dx;
                r_y <= dy;
                r_z <= '0;
            end
        end
        if (i_cmd.iter) begin
            r_iter <= r_iter + 1'b1;
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_q(r_iter);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_q(r_iter);
            end
        end
        if (i_cmd.rho_lo) begin
            r_pl <= 42'(r_x[17:0]) * 42'(INV_GAIN);
        end
        if (i_cmd.rho_hi) begin
            r_ph <= 42'(r_x[XW-1:18]) * 42'(INV_GAIN);
        end
        if (i_cmd.alpha) begin
            r_rho   <= r_zero ? '0 : rho_sum[59:24];
            r_alpha <= wrap_angle(WW'(bear) - WW'(r_theta));
            r_diff  <= wrap_angle(WW'(r_theta) - WW'(gth));
        end
        if (i_cmd.beta) begin
            r_beta  <= wrap_angle(WW'(gth) - WW'(r_theta) - WW'(r_alpha));
            r_vprod <= 52'(r_rho) * 52'(r_gain_distance);
            r_dmag  <= (r_diff < 0) ? AW'(-r_diff) : AW'(r_diff);
        end
        if (i_cmd.prod) begin
            r_pa    <= $signed({1'b0, r_gain_bearing}) * r_alpha;
            r_pb    <= $signed({1'b0, r_gain_final}) * r_beta;
            r_rprod <= 42'(r_dmag) * 42'(r_gain_distance);
        end
        if (i_cmd.fin) begin
            r_lin  <= n_lin;
            r_ang  <= n_ang;
            r_stat <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_docked    <= 1'b0;
            r_turn_sign <= 1'b0;
        end else if (i_cmd.fin) begin
            r_docked    <= n_docked;
            r_turn_sign <= n_turn_sign;
        end
    end

    always_comb begin
        v_u        = r_vprod >> POSITION_FRACTION_BITS;
        alpha_wide = (r_alpha > HALF_PI_Q) || (r_alpha < -HALF_PI_Q);
        vs         = alpha_wide ? -$signed({1'b0, v_u}) : $signed({1'b0, v_u});
        vc         = (vs > $signed(53'(r_speed_cap))) ? $signed(53'(r_speed_cap)) : vs;
        if (vc < -53'sd32768) begin
            vc = -53'sd32768;
        end
        wsum = 46'(r_pa) - 46'(r_pb);
        wsh  = wsum >>> 24;
        wc   = (wsh > $signed(46'(r_turn_cap))) ? $signed(46'(r_turn_cap)) : wsh;
        if (wc < -46'sd32768) begin
            wc = -46'sd32768;
        end
        vb       = (v_u > 52'(r_speed_cap)) ? r_speed_cap : v_u[14:0];
        rr       = r_rprod[41:24];
        rc       = (rr > ROT_CAP) ? ROT_CAP[10:0] : rr[10:0];
        sign_now = r_start ? (r_diff < 0) : r_turn_sign;

        n_lin       = '0;
        n_ang       = '0;
        n_stat      = STAT_MOVING;
        n_docked    = r_docked;
        n_turn_sign = r_turn_sign;
        unique case (r_func)
            FUNC_APPROACH: begin
                if (r_docked) begin
                    n_stat = STAT_DONE;
                end else if (r_rho <= TOL_DOCK) begin
                    n_stat   = STAT_DONE;
                    n_docked = 1'b1;
                end else begin
                    n_lin = vc[15:0];
                    n_ang = wc[15:0];
                end
            end
            FUNC_BACK_OFF: begin
                if (!r_docked) begin
                    n_stat = STAT_REFUSED;
                end else if (r_rho <= TOL_BACK) begin
                    n_stat = STAT_DONE;
                end else begin
                    n_lin = -$signed({1'b0, vb});
                end
            end
            FUNC_ROTATE: begin
                if (!r_docked) begin
                    n_stat = STAT_REFUSED;
                end else begin
                    n_turn_sign = sign_now;
                    if (r_dmag <= ROT_TOL_Q) begin
                        n_stat   = STAT_DONE;
                        n_docked = 1'b0;
                    end else begin
                        n_ang = sign_now ? -$signed({5'b0, rc}) : $signed({5'b0, rc});
                    end
                end
            end
            default: n_stat = STAT_REFUSED;
        endcase
    end

    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;
    assign o_result_status = r_stat;

endmodule

@@ rtl/docking_pose_controller_top.sv @@
// ----------------------------------------------------------------------------
// docking_pose_controller_top
// Polar move-to-pose docking controller: pose sample in, speed command out.
//
//   port       dir  word
//   i_pose     in   func, phase_start, robot_x, robot_y, robot_heading
//   o_cmd      out  linear_speed, angular_speed, status
//   i_cfg_*    in   register write: index 0..7, 32-bit data
//
// An accepted sample passes the init step, the CORDIC vectoring loop (one
// rotation per cycle), the rho, alpha, beta and product steps and the finish
// step before its result is valid. One sample is in work at a time.
// The result register holds a word while o_cmd stalls; the next sample is
// accepted meanwhile and holds in the finish step until the word is taken.
// Synchronous active-low reset clears state and settings, not datapath registers.
// ----------------------------------------------------------------------------
module docking_pose_controller_top import dpc_pkg::*; #(
    parameter int CORDIC_STEPS           = 16,
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    dpc_pose_if.sink    i_pose,
    dpc_cmd_if.source   o_cmd
);

    t_dp_cmd    cmd;
    t_dp_status status;

    dpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pose.valid),
        .o_in_ready  (i_pose.ready),
        .i_out_ready (o_cmd.ready),
        .o_out_valid (o_cmd.valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    dpc_datapath #(
        .CORDIC_STEPS           (CORDIC_STEPS),
        .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_pose.func),
        .i_phase_start   (i_pose.phase_start),
        .i_robot_x       (i_pose.robot_x),
        .i_robot_y       (i_pose.robot_y),
        .i_robot_heading (i_pose.robot_heading),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_linear_speed  (o_cmd.linear_speed),
        .o_angular_speed (o_cmd.angular_speed),
        .o_result_status (o_cmd.status)
    );

endmodule
